[rtl/core/bisv_pkg.sv]
package bisv_pkg;

    // Field widths.
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned SIZE_W = 21;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned PHASE_W = 4;
    localparam int unsigned SECT_W = 5;

    // Default upper bound on the image size.
    localparam int unsigned MAX_IMAGE_BYTES_DEF = 1048576;

    // Image format constants.
    localparam logic [BYTE_W-1:0] CSUM_SEED   = 8'hef;
    localparam logic [BYTE_W-1:0] OUTER_MAGIC = 8'hea;
    localparam logic [BYTE_W-1:0] OUTER_VER   = 8'h04;
    localparam logic [BYTE_W-1:0] APP_MAGIC   = 8'he9;
    localparam logic [BYTE_W-1:0] MAX_SECTS   = 8'd16;
    localparam logic [WORD_W-1:0] IRAM_LO = 32'h4010_0000;
    localparam logic [WORD_W-1:0] IRAM_HI = 32'h4011_0000;
    localparam logic [WORD_W-1:0] DRAM_LO = 32'h3ffe_8000;
    localparam logic [WORD_W-1:0] DRAM_HI = 32'h4000_0000;
    localparam logic [SIZE_W-1:0] HDR_BYTES = 21'd8;
    localparam logic [SIZE_W-1:0] IROM_MIN  = 21'd16;

    // Byte held in the input register.
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } item_t;

    // Verdict handed from the parser to the output register.
    typedef struct packed {
        logic              load;
        logic              image_valid;
        logic [BYTE_W-1:0] checksum;
    } result_t;

    // True when [addr, addr+len) lies inside [lo, hi).
    function automatic logic in_window(
        input logic [WORD_W-1:0] addr,
        input logic [WORD_W-1:0] len,
        input logic [WORD_W-1:0] lo,
        input logic [WORD_W-1:0] hi
    );
        logic [WORD_W-1:0] span;
        span = hi - lo;
        return (addr >= lo) && (len <= span) && (addr <= hi - len);
    endfunction

endpackage

[rtl/core/bisv_ifs.sv]
// Image byte channel.
interface bisv_byte_if;
    logic                        valid;
    logic                        ready;
    logic [bisv_pkg::BYTE_W-1:0] image_byte;

    modport source (output valid, output image_byte, input ready);
    modport sink (input valid, input image_byte, output ready);
endinterface

// Verdict channel.
interface bisv_verdict_if;
    logic                        valid;
    logic                        ready;
    logic                        image_valid;
    logic [bisv_pkg::BYTE_W-1:0] computed_checksum;

    modport source (output valid, output image_valid, output computed_checksum, input ready);
    modport sink (input valid, input image_valid, input computed_checksum, output ready);
endinterface

// Configuration write channel for the image size.
interface bisv_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [bisv_pkg::SIZE_W-1:0] image_size;

    modport source (output valid, output image_size, input ready);
    modport sink (input valid, input image_size, output ready);
endinterface

[rtl/core/bisv_in_stage.sv]
module bisv_in_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [bisv_pkg::BYTE_W-1:0] in_byte,
    output logic                        in_ready,
    input  logic                        take,
    output bisv_pkg::item_t             item
);
    import bisv_pkg::*;

    logic              valid_reg;
    logic [BYTE_W-1:0] data_reg;

    // The register is free when empty or when the parser consumes its byte.
    assign in_ready = !valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= in_byte;
        end
    end

    assign item.valid = valid_reg;
    assign item.data  = data_reg;

endmodule

[rtl/core/bisv_parser.sv]
module bisv_parser #(
    parameter int unsigned MAX_IMAGE_BYTES = bisv_pkg::MAX_IMAGE_BYTES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [bisv_pkg::SIZE_W-1:0] image_size,
    input  bisv_pkg::item_t             item,
    input  logic                        out_free,
    output logic                        take,
    output bisv_pkg::result_t           result
);
    import bisv_pkg::*;

    // Parse phases.
    localparam logic [PHASE_W-1:0] PH_OUTER     = 4'd0;
    localparam logic [PHASE_W-1:0] PH_IROM_HDR  = 4'd1;
    localparam logic [PHASE_W-1:0] PH_IROM_DATA = 4'd2;
    localparam logic [PHASE_W-1:0] PH_PAD1      = 4'd3;
    localparam logic [PHASE_W-1:0] PH_APP_HDR   = 4'd4;
    localparam logic [PHASE_W-1:0] PH_SEC_HDR   = 4'd5;
    localparam logic [PHASE_W-1:0] PH_SEC_DATA  = 4'd6;
    localparam logic [PHASE_W-1:0] PH_PAD2      = 4'd7;
    localparam logic [PHASE_W-1:0] PH_DONE      = 4'd8;

    localparam logic [WORD_W:0] MAX_BYTES = (WORD_W+1)'(MAX_IMAGE_BYTES);

    logic [SIZE_W-1:0]  pos_reg, pos_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [BYTE_W-1:0]  xor_reg, xor_next;
    logic [WORD_W-1:0]  fa_reg, fa_next;
    logic [WORD_W-1:0]  seg_reg, seg_next;
    logic [SIZE_W-1:0]  left_reg, left_next;
    logic [SECT_W-1:0]  sect_reg, sect_next;
    logic               fail_reg, fail_next;

    logic [BYTE_W-1:0]  b;
    logic [SIZE_W-1:0]  pos_inc;
    logic [SIZE_W:0]    pos_p1;
    logic [SIZE_W:0]    rem;
    logic [WORD_W-1:0]  fa_shift;
    logic [SIZE_W-1:0]  left_dec;
    logic [2:0]         idx;
    logic               last;
    logic               size_ok;
    logic               ok;

    // Position bookkeeping and the end-of-image test.
    assign b        = item.data;
    assign pos_inc  = pos_reg + 1'b1;
    assign pos_p1   = {1'b0, pos_reg} + 1'b1;
    assign rem      = {1'b0, image_size} - pos_p1;
    assign fa_shift = {b, fa_reg[WORD_W-1:BYTE_W]};
    assign left_dec = left_reg - 1'b1;
    assign idx      = 3'(4'd8 - left_reg[3:0]);
    assign last     = (pos_inc == image_size);
    assign size_ok  = (image_size != '0) && ({12'd0, image_size} <= MAX_BYTES);

    // A byte moves on unless it ends an image while the output is still full.
    assign take = item.valid && (!last || out_free);

    // Field checks and phase transitions for one byte.
    always_comb
    begin
        phase_next = phase_reg;
        xor_next   = xor_reg;
        fa_next    = fa_reg;
        seg_next   = seg_reg;
        left_next  = left_reg;
        sect_next  = sect_reg;
        fail_next  = fail_reg;
        if (!fail_reg)
        begin
            fa_next = fa_shift;
            case (phase_reg)
                PH_OUTER:
                begin
                    if ((pos_reg == 21'd0 && b != OUTER_MAGIC) ||
                        (pos_reg == 21'd1 && b != OUTER_VER))
                    begin
                        fail_next = 1'b1;
                    end
                    if (pos_reg == 21'd7)
                    begin
                        phase_next = PH_IROM_HDR;
                    end
                end
                PH_IROM_HDR:
                begin
                    if (pos_reg == 21'd11 && fa_shift != '0)
                    begin
                        fail_next = 1'b1;
                    end
                    if (pos_reg == 21'd15)
                    begin
                        if (fa_shift == '0 || image_size < IROM_MIN ||
                            fa_shift > WORD_W'(image_size - IROM_MIN))
                        begin
                            fail_next = 1'b1;
                        end
                        else
                        begin
                            left_next  = fa_shift[SIZE_W-1:0];
                            phase_next = PH_IROM_DATA;
                        end
                    end
                end
                PH_IROM_DATA, PH_SEC_DATA:
                begin
                    xor_next  = xor_reg ^ b;
                    left_next = left_dec;
                    if (left_dec == '0)
                    begin
                        if (phase_reg == PH_IROM_DATA)
                        begin
                            if (pos_inc[3:0] == 4'd0)
                            begin
                                phase_next = PH_APP_HDR;
                                left_next  = HDR_BYTES;
                            end
                            else
                            begin
                                phase_next = PH_PAD1;
                            end
                        end
                        else if (sect_reg != '0)
                        begin
                            phase_next = PH_SEC_HDR;
                            left_next  = HDR_BYTES;
                        end
                        else
                        begin
                            phase_next = PH_PAD2;
                        end
                    end
                end
                PH_PAD1:
                begin
                    if (pos_inc[3:0] == 4'd0)
                    begin
                        phase_next = PH_APP_HDR;
                        left_next  = HDR_BYTES;
                    end
                end
                PH_APP_HDR:
                begin
                    left_next = left_dec;
                    if (idx == 3'd0 && b != APP_MAGIC)
                    begin
                        fail_next = 1'b1;
                    end
                    if (idx == 3'd1)
                    begin
                        if (b == '0 || b > MAX_SECTS)
                        begin
                            fail_next = 1'b1;
                        end
                        sect_next = b[SECT_W-1:0];
                    end
                    if (idx == 3'd7)
                    begin
                        // Entry point must sit in IRAM.
                        if (!in_window(fa_shift, 32'd1, IRAM_LO, IRAM_HI))
                        begin
                            fail_next = 1'b1;
                        end
                        phase_next = PH_SEC_HDR;
                        left_next  = HDR_BYTES;
                    end
                end
                PH_SEC_HDR:
                begin
                    left_next = left_dec;
                    if (idx == 3'd3)
                    begin
                        seg_next = fa_shift;
                    end
                    if (idx == 3'd7)
                    begin
                        // Section length must fit the image and the range one window.
                        if (fa_shift == '0 || pos_p1 > {1'b0, image_size} ||
                            fa_shift > WORD_W'(rem))
                        begin
                            fail_next = 1'b1;
                        end
                        else if (!in_window(seg_reg, fa_shift, IRAM_LO, IRAM_HI) &&
                                 !in_window(seg_reg, fa_shift, DRAM_LO, DRAM_HI))
                        begin
                            fail_next = 1'b1;
                        end
                        else
                        begin
                            left_next  = fa_shift[SIZE_W-1:0];
                            sect_next  = sect_reg - 1'b1;
                            phase_next = PH_SEC_DATA;
                        end
                    end
                end
                PH_PAD2:
                begin
                    if (pos_reg[3:0] == 4'hf)
                    begin
                        if (b != xor_reg)
                        begin
                            fail_next = 1'b1;
                        end
                        phase_next = PH_DONE;
                    end
                end
                default:
                begin
                    fail_next = 1'b1;
                end
            endcase
        end
        pos_next = pos_inc;
    end

    // Verdict for the final byte of an image.
    assign ok = !fail_next && (phase_next == PH_DONE) && size_ok;

    assign result.load        = take && last;
    assign result.image_valid = ok;
    assign result.checksum    = xor_next;

    // Parse state; the final byte of an image rearms everything.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            phase_reg <= PH_OUTER;
            xor_reg   <= CSUM_SEED;
            fa_reg    <= '0;
            seg_reg   <= '0;
            left_reg  <= '0;
            sect_reg  <= '0;
            fail_reg  <= 1'b0;
        end
        else if (take)
        begin
            if (last)
            begin
                pos_reg   <= '0;
                phase_reg <= PH_OUTER;
                xor_reg   <= CSUM_SEED;
                fa_reg    <= '0;
                seg_reg   <= '0;
                left_reg  <= '0;
                sect_reg  <= '0;
                fail_reg  <= 1'b0;
            end
            else
            begin
                pos_reg   <= pos_next;
                phase_reg <= phase_next;
                xor_reg   <= xor_next;
                fa_reg    <= fa_next;
                seg_reg   <= seg_next;
                left_reg  <= left_next;
                sect_reg  <= sect_next;
                fail_reg  <= fail_next;
            end
        end
    end

endmodule

[rtl/core/bisv_out_stage.sv]
module bisv_out_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bisv_pkg::result_t           result,
    output logic                        out_free,
    output logic                        out_valid,
    output logic                        out_image_valid,
    output logic [bisv_pkg::BYTE_W-1:0] out_checksum,
    input  logic                        out_ready
);
    import bisv_pkg::*;

    logic              valid_reg;
    logic              ok_reg;
    logic [BYTE_W-1:0] csum_reg;

    // The register can take a verdict when empty or being drained.
    assign out_free = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            valid_reg <= result.load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.load)
        begin
            ok_reg   <= result.image_valid;
            csum_reg <= result.checksum;
        end
    end

    assign out_valid       = valid_reg;
    assign out_image_valid = ok_reg;
    assign out_checksum    = csum_reg;

endmodule

[rtl/core/boot_image_stream_validator.sv]
// Flow: a byte is registered in the input register on acceptance and parsed
// from there; the verdict for the final byte of an image is then registered in
// the output register. Throughput: one byte per cycle; the final byte waits
// only while a previous verdict sits in the output register and is not read.
// Reset: rst_n clears the parser to the outer header phase, empties both
// registers and sets the image size to 1.
module boot_image_stream_validator #(
    parameter int unsigned MAX_IMAGE_BYTES = bisv_pkg::MAX_IMAGE_BYTES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    bisv_byte_if.sink     image,
    bisv_verdict_if.source verdict,
    bisv_cfg_if.sink      cfg
);
    import bisv_pkg::*;

    logic [SIZE_W-1:0] image_size_reg;
    item_t             item;
    result_t           result;
    logic              take;
    logic              out_free;

    // Image size register; write it only while the block is idle (not enforced here).
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_size_reg <= 21'd1;
        end
        else if (cfg.valid)
        begin
            image_size_reg <= cfg.image_size;
        end
    end

    // Input register.
    bisv_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (image.valid),
        .in_byte  (image.image_byte),
        .in_ready (image.ready),
        .take     (take),
        .item     (item)
    );

    // Header parsing, range checks and checksum.
    bisv_parser #(
        .MAX_IMAGE_BYTES (MAX_IMAGE_BYTES)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .image_size (image_size_reg),
        .item       (item),
        .out_free   (out_free),
        .take       (take),
        .result     (result)
    );

    // Verdict register.
    bisv_out_stage u_out (
        .clk             (clk),
        .rst_n           (rst_n),
        .result          (result),
        .out_free        (out_free),
        .out_valid       (verdict.valid),
        .out_image_valid (verdict.image_valid),
        .out_checksum    (verdict.computed_checksum),
        .out_ready       (verdict.ready)
    );

endmodule
